[rtl/ssd_pkg.sv]
package ssd_pkg;

   localparam int WINDOW_SAMPLES = 5;
   localparam int SAMPLE_W       = 12;
   localparam int TIME_W         = 16;
   localparam int COUNT_W        = $clog2(WINDOW_SAMPLES + 1);
   localparam int TOTAL_W        = SAMPLE_W + $clog2(WINDOW_SAMPLES);

   // Floor division of the window sum by WINDOW_SAMPLES as a multiply by a
   // rounded-up reciprocal. With the shift at TOTAL_W plus the bits of the
   // divisor, the rounding error never reaches the next integer.
   localparam int RECIP_SHIFT = TOTAL_W + $clog2(WINDOW_SAMPLES);
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PRODUCT_W   = TOTAL_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(WINDOW_SAMPLES - 1);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
   localparam logic [TIME_W-1:0]   TIME_MAX   = '1;

   localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(5);
   localparam logic [TIME_W-1:0]   TIMEOUT_RESET   = TIME_W'(500);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS       = 1'b1;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic [1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_TICK    = 2'd1,
      ACT_RESTART = 2'd2
   } action_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] stable_threshold;
      logic [TIME_W-1:0]   timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic                settled;
      logic [SAMPLE_W-1:0] mean_value;
      logic [TIME_W-1:0]   settle_time_ms;
   } result_type;

endpackage

[rtl/sensor_settle_detector_core.sv]
// Settle detector for averaged 12-bit ADC readings. Each input transaction
// is a sample, a one-millisecond tick or a restart, chosen by req_tuser.
// Samples are gathered in windows of five; at the end of each window the
// block reports success (settled = 1, window mean, elapsed ms) if the
// spread max - min is below stable_threshold, or failure (settled = 0,
// window mean, timeout_ms) if the elapsed time already exceeds timeout_ms,
// and otherwise starts a new window. After a report, samples and ticks are
// ignored until a restart. One transaction is taken every clock cycle while
// req_tready is high: each one updates the window registers, and a report
// lands in a two-entry output register with skid stage, so req_tready drops
// only when two reports wait on rsp_tready. Configuration writes are always
// accepted and must only be made while the block is idle.
module sensor_settle_detector_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ssd_pkg::REQ_TDATA_W-1:0]      req_tdata,  // [11:0] sample
   input  logic [1:0]                           req_tuser,  // [1:0] action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [11:0] mean_value, [27:12] settle_time_ms
   output logic [ssd_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser,  // [0] settled
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]       csr_data
);

   ssd_pkg::cfg_type    cfg;
   ssd_pkg::result_type win_res, out_res;
   logic                win_res_valid, queue_full, req_accept;

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   ssd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ssd_window u_window (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_accept),
      .action     (ssd_pkg::action_type'(req_tuser)),
      .sample     (req_tdata[ssd_pkg::SAMPLE_W-1:0]),
      .cfg        (cfg),
      .res_valid  (win_res_valid),
      .res        (win_res)
   );

   ssd_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (win_res_valid),
      .push_data (win_res),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tuser = out_res.settled;
   assign rsp_tdata = {
      (ssd_pkg::RSP_TDATA_W - ssd_pkg::SAMPLE_W - ssd_pkg::TIME_W)'(0),
      out_res.settle_time_ms,
      out_res.mean_value
   };

endmodule

[rtl/ssd_csr.sv]
module ssd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]     csr_data,
   output ssd_pkg::cfg_type                   cfg
);

   ssd_pkg::cfg_type cfg_ff;
   ssd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ssd_pkg::CSR_STABLE_THRESHOLD:
               cfg_in.stable_threshold = csr_data[ssd_pkg::SAMPLE_W-1:0];
            ssd_pkg::CSR_TIMEOUT_MS:
               cfg_in.timeout_ms = csr_data[ssd_pkg::TIME_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stable_threshold <= ssd_pkg::THRESHOLD_RESET;
         cfg_ff.timeout_ms       <= ssd_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/ssd_window.sv]
module ssd_window (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  ssd_pkg::action_type               action,
   input  logic [ssd_pkg::SAMPLE_W-1:0]      sample,
   input  ssd_pkg::cfg_type                  cfg,
   output logic                              res_valid,
   output ssd_pkg::result_type               res
);

   logic [ssd_pkg::COUNT_W-1:0]  window_count_ff, window_count_in;
   logic [ssd_pkg::SAMPLE_W-1:0] window_low_ff, window_low_in;
   logic [ssd_pkg::SAMPLE_W-1:0] window_high_ff, window_high_in;
   logic [ssd_pkg::TOTAL_W-1:0]  window_total_ff, window_total_in;
   logic [ssd_pkg::TIME_W-1:0]   elapsed_ms_ff, elapsed_ms_in;
   logic                         active_ff, active_in;

   logic [ssd_pkg::SAMPLE_W-1:0]  low_upd, high_upd, spread;
   logic [ssd_pkg::TOTAL_W-1:0]   total_upd;
   logic [ssd_pkg::PRODUCT_W-1:0] product;
   logic                          take_sample, window_done, is_stable, timed_out;

   assign take_sample = item_valid && active_ff && (action == ssd_pkg::ACT_SAMPLE);
   assign window_done = (window_count_ff == ssd_pkg::LAST_COUNT);

   assign low_upd   = (sample < window_low_ff)  ? sample : window_low_ff;
   assign high_upd  = (sample > window_high_ff) ? sample : window_high_ff;
   assign total_upd = window_total_ff + ssd_pkg::TOTAL_W'(sample);
   assign spread    = high_upd - low_upd;
   assign is_stable = spread < cfg.stable_threshold;
   assign timed_out = elapsed_ms_ff > cfg.timeout_ms;

   assign product = ssd_pkg::PRODUCT_W'(total_upd) * ssd_pkg::PRODUCT_W'(ssd_pkg::RECIP_MULT);

   assign res_valid = take_sample && window_done && (is_stable || timed_out);
   assign res.settled        = is_stable;
   assign res.mean_value     = product[ssd_pkg::RECIP_SHIFT +: ssd_pkg::SAMPLE_W];
   assign res.settle_time_ms = is_stable ? elapsed_ms_ff : cfg.timeout_ms;

   always_comb begin
      window_count_in = window_count_ff;
      window_low_in   = window_low_ff;
      window_high_in  = window_high_ff;
      window_total_in = window_total_ff;
      elapsed_ms_in   = elapsed_ms_ff;
      active_in       = active_ff;
      if (item_valid) begin
         unique case (action)
            ssd_pkg::ACT_RESTART: begin
               window_count_in = '0;
               window_low_in   = ssd_pkg::SAMPLE_MAX;
               window_high_in  = '0;
               window_total_in = '0;
               elapsed_ms_in   = '0;
               active_in       = 1'b1;
            end
            ssd_pkg::ACT_TICK: begin
               if (active_ff && elapsed_ms_ff != ssd_pkg::TIME_MAX) begin
                  elapsed_ms_in = elapsed_ms_ff + 1'b1;
               end
            end
            ssd_pkg::ACT_SAMPLE: begin
               if (take_sample) begin
                  if (window_done) begin
                     // A full window is always cleared, whatever its verdict.
                     window_count_in = '0;
                     window_low_in   = ssd_pkg::SAMPLE_MAX;
                     window_high_in  = '0;
                     window_total_in = '0;
                     if (res_valid) begin
                        active_in = 1'b0;
                     end
                  end else begin
                     window_count_in = window_count_ff + 1'b1;
                     window_low_in   = low_upd;
                     window_high_in  = high_upd;
                     window_total_in = total_upd;
                  end
               end
            end
            default: active_in = active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_count_ff <= '0;
         window_low_ff   <= ssd_pkg::SAMPLE_MAX;
         window_high_ff  <= '0;
         window_total_ff <= '0;
         elapsed_ms_ff   <= '0;
         active_ff       <= 1'b1;
      end else begin
         window_count_ff <= window_count_in;
         window_low_ff   <= window_low_in;
         window_high_ff  <= window_high_in;
         window_total_ff <= window_total_in;
         elapsed_ms_ff   <= elapsed_ms_in;
         active_ff       <= active_in;
      end
   end

   a_result_only_when_active: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> active_ff)
      else $error("result produced while no measurement was running");

   a_result_stops_measurement: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> !active_ff && window_count_ff == '0)
      else $error("measurement still running after a result");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      window_count_ff <= ssd_pkg::LAST_COUNT)
      else $error("window count ran past the window length");

   a_idle_window_empty: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> window_count_ff == '0)
      else $error("window holds samples while idle");

endmodule

[rtl/ssd_out_queue.sv]
module ssd_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ssd_pkg::result_type  push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ssd_pkg::result_type  out_data
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   ssd_pkg::result_type out_data_ff, out_data_in;
   ssd_pkg::result_type skid_data_ff, skid_data_in;
   logic                pop, load_out;

   assign pop      = out_valid_ff && out_ready;
   assign load_out = !out_valid_ff || pop;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (load_out) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed into a full queue");

   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while the head is empty");

   a_skid_kept: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !pop |=> skid_valid_ff && out_valid_ff)
      else $error("queued result lost without a transaction");

endmodule

[bench/settle_checker.sv]
module settle_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   input  logic                                     req_tready,
   input  logic [ssd_pkg::REQ_TDATA_W-1:0]          req_tdata,
   input  logic [1:0]                               req_tuser,
   input  logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   input  logic [ssd_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   input  logic                                     rsp_tuser,
   input  logic                                     csr_valid,
   input  logic                                     csr_ready,
   input  logic [ssd_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]           csr_data,
   output int                                       outstanding,
   output int                                       mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the configuration and of the measurement state.
   logic [ssd_pkg::SAMPLE_W-1:0] threshold_now;
   logic [ssd_pkg::TIME_W-1:0]   timeout_now;
   int unsigned                  win_count;
   int unsigned                  win_total;
   logic [ssd_pkg::SAMPLE_W-1:0] win_low;
   logic [ssd_pkg::SAMPLE_W-1:0] win_high;
   logic [ssd_pkg::TIME_W-1:0]   elapsed;
   logic                         running;

   ssd_pkg::result_type expected_reports[$];

   task automatic clear_window();
      win_count = 0;
      win_total = 0;
      win_low   = ssd_pkg::SAMPLE_MAX;
      win_high  = '0;
   endtask

   // Applies one accepted transaction to the shadow state and queues the
   // report it produces, if any.
   task automatic advance_measurement(input logic [1:0] act,
                                      input logic [ssd_pkg::SAMPLE_W-1:0] smp);
      ssd_pkg::result_type rep;
      if (act == ssd_pkg::ACT_RESTART) begin
         clear_window();
         elapsed = '0;
         running = 1'b1;
      end else if (running && act == ssd_pkg::ACT_TICK) begin
         if (elapsed != ssd_pkg::TIME_MAX)
            elapsed = elapsed + 1'b1;
      end else if (running && act == ssd_pkg::ACT_SAMPLE) begin
         if (smp < win_low)
            win_low = smp;
         if (smp > win_high)
            win_high = smp;
         win_total += smp;
         win_count++;
         if (win_count == ssd_pkg::WINDOW_SAMPLES) begin
            rep.mean_value = ssd_pkg::SAMPLE_W'(win_total / ssd_pkg::WINDOW_SAMPLES);
            if (win_high - win_low < threshold_now) begin
               rep.settled        = 1'b1;
               rep.settle_time_ms = elapsed;
               expected_reports.push_back(rep);
               running = 1'b0;
            end else if (elapsed > timeout_now) begin
               rep.settled        = 1'b0;
               rep.settle_time_ms = timeout_now;
               expected_reports.push_back(rep);
               running = 1'b0;
            end
            clear_window();
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      ssd_pkg::result_type got;
      ssd_pkg::result_type want;
      if (reset) begin
         threshold_now = ssd_pkg::THRESHOLD_RESET;
         timeout_now   = ssd_pkg::TIMEOUT_RESET;
         clear_window();
         elapsed = '0;
         running = 1'b1;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ssd_pkg::CSR_STABLE_THRESHOLD)
               threshold_now = csr_data[ssd_pkg::SAMPLE_W-1:0];
            else if (csr_index == ssd_pkg::CSR_TIMEOUT_MS)
               timeout_now = csr_data[ssd_pkg::TIME_W-1:0];
         end
         // A report accepted at this edge can only belong to an earlier
         // request, so it is matched before this edge's request is applied.
         if (rsp_tvalid && rsp_tready) begin
            got.settled        = rsp_tuser;
            got.mean_value     = rsp_tdata[ssd_pkg::SAMPLE_W-1:0];
            got.settle_time_ms =
               rsp_tdata[ssd_pkg::SAMPLE_W+ssd_pkg::TIME_W-1:ssd_pkg::SAMPLE_W];
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected report settled=%0d mean=%0d time=%0d",
                           $realtime, got.settled, got.mean_value,
                           got.settle_time_ms);
            end else begin
               want = expected_reports.pop_front();
               if (got.settled !== want.settled ||
                   got.mean_value !== want.mean_value ||
                   got.settle_time_ms !== want.settle_time_ms) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display(
                        "%0t: settled/mean/time expected %0d/%0d/%0d, got %0d/%0d/%0d",
                        $realtime, want.settled, want.mean_value,
                        want.settle_time_ms, got.settled, got.mean_value,
                        got.settle_time_ms);
               end
            end
         end
         if (req_tvalid && req_tready)
            advance_measurement(req_tuser, req_tdata[ssd_pkg::SAMPLE_W-1:0]);
      end
      outstanding = expected_reports.size();
   end

endmodule

[bench/tb_sensor_settle_detector_core.sv]
module tb_sensor_settle_detector_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNDEFINED = 2'd3;
   localparam int RANDOM_ITEMS = 2000;
   localparam int SEGMENTS     = 12;
   localparam int DRAIN_CYCLES = 8;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [ssd_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic [1:0]                        req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ssd_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [ssd_pkg::CSR_INDEX_W-1:0]   csr_index  = '0;
   logic [ssd_pkg::CSR_DATA_W-1:0]    csr_data   = '0;

   int outstanding;
   int mismatches;
   int send_idle_pct = 34;
   int recv_idle_pct = 72;
   int items_sent    = 0;
   int cur_thr       = 5;

   sensor_settle_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   settle_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_item(input logic [1:0] act,
                            input logic [ssd_pkg::SAMPLE_W-1:0] smp);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= ssd_pkg::REQ_TDATA_W'(smp);
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Holds the sender off until every predicted report has been taken and
   // the block has had time to finish transactions that report nothing.
   task automatic settle_down();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [ssd_pkg::CSR_DATA_W-1:0] thr_word,
                            input logic [ssd_pkg::CSR_DATA_W-1:0] tmo_word);
      csr_valid <= 1'b1;
      csr_index <= ssd_pkg::CSR_STABLE_THRESHOLD;
      csr_data  <= thr_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= ssd_pkg::CSR_TIMEOUT_MS;
      csr_data  <= tmo_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_thr = thr_word[ssd_pkg::SAMPLE_W-1:0];
   endtask

   // Restart, then a few windows of ticks and samples with a chosen spread.
   // A small share of samples is replaced by arbitrary transactions, which may
   // break a window with a restart or an undefined action.
   task automatic run_measurements(input int quota);
      int stop_at;
      int windows;
      int ticks;
      int spread;
      int lo;
      stop_at = items_sent + quota;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0)
            settle_down();
         send_item(ssd_pkg::ACT_RESTART, 12'($urandom));
         windows = $urandom_range(1, 4);
         repeat (windows) begin
            ticks = $urandom_range(0, 6);
            repeat (ticks) send_item(ssd_pkg::ACT_TICK, 12'($urandom));
            case ($urandom_range(0, 3))
               0, 1: spread = $urandom_range(0, cur_thr);
               2: spread = (cur_thr + 2 > 4095) ? 4095 : cur_thr + $urandom_range(0, 2);
               default: spread = $urandom_range(0, 4095);
            endcase
            lo = $urandom_range(0, 4095 - spread);
            repeat (ssd_pkg::WINDOW_SAMPLES) begin
               if ($urandom_range(0, 19) == 0)
                  send_item(2'($urandom), 12'($urandom));
               else
                  send_item(ssd_pkg::ACT_SAMPLE, 12'(lo + $urandom_range(0, spread)));
            end
         end
      end
   endtask

   initial begin
      int thr;
      int tmo;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: full-scale window settles at once.
      repeat (ssd_pkg::WINDOW_SAMPLES) send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      // Stopped after a report: these are ignored.
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_TICK, '0);
      // Spread one below the threshold settles; the undefined action in the
      // middle of the window must not count as a sample.
      send_item(ssd_pkg::ACT_RESTART, '0);
      send_item(ssd_pkg::ACT_TICK, '0);
      send_item(ssd_pkg::ACT_TICK, '0);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ACT_UNDEFINED, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, 12'd4);
      // Spread equal to the threshold does not settle and gives no report.
      send_item(ssd_pkg::ACT_RESTART, '0);
      repeat (ssd_pkg::WINDOW_SAMPLES - 1) send_item(ssd_pkg::ACT_SAMPLE, 12'd100);
      send_item(ssd_pkg::ACT_SAMPLE, 12'd105);

      // Zero threshold and zero timeout: a flat window cannot settle, and
      // after one tick the next window fails.
      settle_down();
      configure(16'hF000, 16'h0000);
      send_item(ssd_pkg::ACT_RESTART, '0);
      repeat (ssd_pkg::WINDOW_SAMPLES) send_item(ssd_pkg::ACT_SAMPLE, 12'd7);
      send_item(ssd_pkg::ACT_TICK, '0);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, 12'd2048);
      send_item(ssd_pkg::ACT_SAMPLE, 12'd1);
      send_item(ssd_pkg::ACT_SAMPLE, 12'd4094);

      // Largest threshold: a full-spread window never settles. With the
      // elapsed time equal to the timeout it is not yet a failure; one more
      // tick and the next window fails.
      settle_down();
      configure(16'h0FFF, 16'h0003);
      send_item(ssd_pkg::ACT_RESTART, '0);
      repeat (3) send_item(ssd_pkg::ACT_TICK, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_TICK, '0);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);
      send_item(ssd_pkg::ACT_SAMPLE, '0);
      send_item(ssd_pkg::ACT_SAMPLE, ssd_pkg::SAMPLE_MAX);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct = 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS / 3; seg++) begin
            case (seg)
               0: begin
                  thr = 0;
                  tmo = $urandom_range(0, 20);
               end
               1: begin
                  thr = $urandom_range(1, 40);
                  tmo = $urandom_range(0, 30);
               end
               2: begin
                  thr = 4095;
                  tmo = 65535;
               end
               default: begin
                  thr = $urandom_range(0, 4095);
                  tmo = $urandom_range(0, 65535);
               end
            endcase
            settle_down();
            configure({4'($urandom), 12'(thr)}, 16'(tmo));
            run_measurements(RANDOM_ITEMS / SEGMENTS);
         end
      end

      settle_down();
      if (mismatches == 0)
         $display("sensor_settle_detector_core regression: pass");
      else
         $display("sensor_settle_detector_core regression: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("sensor_settle_detector_core regression: fail");
      $finish;
   end

endmodule
